// ===== sv/pdvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdvm_pkg
// Shared types, register codes and helpers for the perspective divide block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdvm_pkg;

  localparam int unsigned DIV_CELLS = 33;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEWPORT_X      = 3'd0,
    REG_VIEWPORT_Y      = 3'd1,
    REG_VIEWPORT_WIDTH  = 3'd2,
    REG_VIEWPORT_HEIGHT = 3'd3,
    REG_DEPTH_NEAR      = 3'd4,
    REG_DEPTH_FAR       = 3'd5
  } cfg_reg_t;

  // item traveling down the divider chain
  typedef struct packed {
    logic [31:0]        rem;
    logic [32:0]        quo;
    logic [31:0]        mag;
    logic               neg;
    logic               wz;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } div_t;

  // viewport and depth setup
  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [16:0]        near;
    logic [16:0]        far;
  } view_cfg_t;

  // clamp a wide signed value to signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(Q_MAX)) r = Q_MAX;
    else if (v < 64'(Q_MIN)) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pdvm_if.sv =====
// ----------------------------------------------------------------------------
// pdvm_if
// Valid/ready channels for clip-space vertices and window-space results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdvm_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] clip_x;
  logic signed [31:0] clip_y;
  logic signed [31:0] clip_z;
  logic signed [31:0] clip_w;

  modport source (output valid, clip_x, clip_y, clip_z, clip_w, input ready);
  modport sink   (input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface

interface pdvm_window_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_x;
  logic signed [31:0] window_y;
  logic signed [31:0] window_depth;
  logic signed [31:0] inverse_w;
  logic               w_zero;

  modport source (output valid, window_x, window_y, window_depth, inverse_w, w_zero,
                  input ready);
  modport sink   (input valid, window_x, window_y, window_depth, inverse_w, w_zero,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/pdvm_div_cell.sv =====
// ----------------------------------------------------------------------------
// pdvm_div_cell
// One restoring-division step: produces one quotient bit of 2^32 / |w|.
// ----------------------------------------------------------------------------
`default_nettype none

module pdvm_div_cell
  import pdvm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic bit_in,
  input  wire logic in_valid,
  input  wire div_t in_data,
  output logic      out_valid,
  output div_t      out_data
);

  logic [32:0] trial;
  logic        ge;
  div_t        data_next;

  // shift in the next dividend bit and try to subtract
  always_comb begin
    trial = {in_data.rem, bit_in};
    ge = trial >= {1'b0, in_data.mag};
    data_next = in_data;
    data_next.rem = ge ? 32'(trial - {1'b0, in_data.mag}) : trial[31:0];
    data_next.quo = {in_data.quo[31:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pdvm_map.sv =====
// ----------------------------------------------------------------------------
// pdvm_map
// Reciprocal sign/saturate, NDC multiply and viewport/depth mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module pdvm_map
  import pdvm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire logic      in_valid,
  input  wire div_t      in_data,
  input  wire view_cfg_t cfg,
  pdvm_window_if.source  out
);

  // stage 1: signed, saturated reciprocal
  logic               s1_valid;
  logic signed [31:0] s1_inv;
  logic               s1_wz;
  logic signed [31:0] s1_x, s1_y, s1_z;
  logic signed [63:0] q_signed;
  logic signed [31:0] inv_next;

  always_comb begin
    q_signed = in_data.neg ? -$signed({31'd0, in_data.quo}) : $signed({31'd0, in_data.quo});
    inv_next = in_data.wz ? Q_MAX : sat32(q_signed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_inv <= inv_next;
      s1_wz  <= in_data.wz;
      s1_x   <= in_data.x;
      s1_y   <= in_data.y;
      s1_z   <= in_data.z;
    end
  end

  // stage 2: normalized device coordinates
  function automatic logic signed [31:0] ndc(input logic signed [31:0] c,
                                             input logic signed [31:0] inv,
                                             input logic wz);
    logic signed [63:0] p;
    logic signed [31:0] r;
    p = c * inv;
    if (wz) r = (c > 0) ? Q_MAX : ((c < 0) ? Q_MIN : 32'sd0);
    else r = sat32(p >>> 16);
    return r;
  endfunction

  logic               s2_valid;
  logic signed [31:0] s2_inv;
  logic               s2_wz;
  logic signed [31:0] s2_nx, s2_ny, s2_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_inv <= s1_inv;
      s2_wz  <= s1_wz;
      s2_nx  <= ndc(s1_x, s1_inv, s1_wz);
      s2_ny  <= ndc(s1_y, s1_inv, s1_wz);
      s2_nz  <= ndc(s1_z, s1_inv, s1_wz);
    end
  end

  // stage 3: window mapping
  function automatic logic signed [31:0] map_axis(input logic signed [31:0] n,
                                                  input logic [14:0] size,
                                                  input logic signed [15:0] org);
    logic signed [15:0] span;
    logic signed [63:0] v;
    span = (size == 15'd0) ? 16'sd0 : $signed({1'b0, size - 15'd1});
    v = (64'(n) * 64'(span)) >>> 1;
    v = v + (64'(org) <<< 16) + (64'(span) <<< 15);
    return sat32(v);
  endfunction

  logic signed [17:0] dr;
  logic signed [63:0] depth_p;

  always_comb begin
    dr = $signed({1'b0, cfg.far}) - $signed({1'b0, cfg.near});
    depth_p = ((64'(s2_nz) + 64'sd65536) * 64'(dr)) >>> 18;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (adv) begin
      out.valid <= s2_valid;
    end
    if (adv) begin
      out.window_x     <= map_axis(s2_nx, cfg.width, cfg.vx);
      out.window_y     <= map_axis(s2_ny, cfg.height, cfg.vy);
      out.window_depth <= sat32(depth_p);
      out.inverse_w    <= s2_inv;
      out.w_zero       <= s2_wz;
    end
  end

endmodule

`default_nettype wire

// ===== sv/perspective_divide_viewport_map_top.sv =====
// Pipeline: an accepted vertex passes 33 divider cells, then the reciprocal,
// NDC multiply and viewport mapping stages.
// Throughput: one vertex per cycle; the pipeline holds only when the result
// register is full and not taken.
// Reset: synchronous, active high; clears valid bits and sets the viewport
// registers to x=0, y=0, width=1, height=1, near=0.0, far=1.0.
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map_top
// Perspective divide of clip-space vertices and mapping to window space.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_divide_viewport_map_top
  import pdvm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  pdvm_vertex_if.sink                vtx_in,
  pdvm_window_if.source              win_out
);

  view_cfg_t cfg;
  logic      adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vx     <= 16'sd0;
      cfg.vy     <= 16'sd0;
      cfg.width  <= 15'd1;
      cfg.height <= 15'd1;
      cfg.near   <= 17'd0;
      cfg.far    <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VIEWPORT_X:      cfg.vx     <= cfg_data[15:0];
        REG_VIEWPORT_Y:      cfg.vy     <= cfg_data[15:0];
        REG_VIEWPORT_WIDTH:  cfg.width  <= cfg_data[14:0];
        REG_VIEWPORT_HEIGHT: cfg.height <= cfg_data[14:0];
        REG_DEPTH_NEAR:      cfg.near   <= cfg_data;
        REG_DEPTH_FAR:       cfg.far    <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the result register is stuck
  assign adv = !win_out.valid || win_out.ready;
  assign vtx_in.ready = adv;

  div_t stg_data  [0:DIV_CELLS];
  logic stg_valid [0:DIV_CELLS];

  // entry: magnitude and sign of w
  always_comb begin
    stg_valid[0]     = vtx_in.valid;
    stg_data[0].rem  = 32'd0;
    stg_data[0].quo  = 33'd0;
    stg_data[0].mag  = vtx_in.clip_w[31] ? 32'(-vtx_in.clip_w) : vtx_in.clip_w;
    stg_data[0].neg  = vtx_in.clip_w[31];
    stg_data[0].wz   = vtx_in.clip_w == 32'sd0;
    stg_data[0].x    = vtx_in.clip_x;
    stg_data[0].y    = vtx_in.clip_y;
    stg_data[0].z    = vtx_in.clip_z;
  end

  // divider chain, dividend 2^32 fed MSB first
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    pdvm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .bit_in    (i == 0),
      .in_valid  (stg_valid[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  pdvm_map u_map (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (stg_valid[DIV_CELLS]),
    .in_data  (stg_data[DIV_CELLS]),
    .cfg      (cfg),
    .out      (win_out)
  );

endmodule

`default_nettype wire

// ===== sim/perspective_divide_viewport_map_top_test.sv =====
// ----------------------------------------------------------------------------
// perspective_divide_viewport_map_top_test
// Drives clip-space vertices through the perspective divide and viewport mapping block
// under random source gaps and sink stalls, predicts each window-space result in fixed
// point or takes a typed-in one, and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_divide_viewport_map_top_test;
  import pdvm_pkg::*;

  localparam int LATENCY    = 36;
  localparam int WATCHDOG   = 4000;
  localparam int N_RANDOM   = 830;
  localparam int LONG_STALL = 150;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } vertex_t;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] depth;
    logic signed [31:0] inv;
    logic               wz;
  } window_t;

  // directed row: vertex plus an optional typed-in result
  typedef struct {
    vertex_t v;
    bit      has_exp;
    window_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pdvm_vertex_if vtx_in ();
  pdvm_window_if win_out ();

  perspective_divide_viewport_map_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .vtx_in(vtx_in.sink), .win_out(win_out.source)
  );

  always #1 clk = ~clk;

  // local copy of the viewport setup
  logic signed [15:0] vp_x;
  logic signed [15:0] vp_y;
  logic [14:0] vp_w;
  logic [14:0] vp_h;
  logic [16:0] dep_near;
  logic [16:0] dep_far;

  window_t pending_windows[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  sink_hold = 1'b0;
  bit  timed_out = 1'b0;

  function automatic longint floor_shr(longint p, int s);
    return p >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint axis_map(longint ndc, logic [14:0] size,
                                      logic signed [15:0] origin);
    longint span;
    span = (size == 0) ? 0 : longint'(size) - 1;
    return clamp32(floor_shr(ndc * span, 1) + longint'(origin) * 65536 + span * 32768);
  endfunction

  // fixed-point perspective divide and viewport transform
  function automatic window_t project_vertex(vertex_t v);
    window_t r;
    longint inv, mag, nx, ny, nz, dr;
    longint c[3];
    longint n[3];
    r.wz = (v.w == 0);
    if (r.wz) begin
      inv = 64'sd2147483647;
    end else begin
      mag = (v.w < 0) ? -longint'(v.w) : longint'(v.w);
      inv = (64'sd1 << 32) / mag;
      inv = clamp32((v.w < 0) ? -inv : inv);
    end
    c[0] = v.x; c[1] = v.y; c[2] = v.z;
    for (int i = 0; i < 3; i++) begin
      if (r.wz) n[i] = c[i] > 0 ? 64'sd2147483647 : (c[i] < 0 ? -64'sd2147483648 : 0);
      else n[i] = clamp32(floor_shr(c[i] * inv, 16));
    end
    nx = n[0]; ny = n[1]; nz = n[2];
    dr = longint'(dep_far) - longint'(dep_near);
    r.depth = 32'(clamp32(floor_shr((nz + 65536) * dr, 18)));
    r.wx = 32'(axis_map(nx, vp_w, vp_x));
    r.wy = 32'(axis_map(ny, vp_h, vp_y));
    r.inv = 32'(inv);
    return r;
  endfunction

  // register write, mirrored into the local setup
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_VIEWPORT_X:      vp_x = val[15:0];
      REG_VIEWPORT_Y:      vp_y = val[15:0];
      REG_VIEWPORT_WIDTH:  vp_w = val[14:0];
      REG_VIEWPORT_HEIGHT: vp_h = val[14:0];
      REG_DEPTH_NEAR:      dep_near = val;
      REG_DEPTH_FAR:       dep_far = val;
      default: ;
    endcase
  endtask

  task automatic set_view(logic [15:0] x, logic [15:0] y, logic [14:0] w,
                          logic [14:0] h, logic [16:0] nr, logic [16:0] fr);
    write_reg(REG_VIEWPORT_X, 17'(x));
    write_reg(REG_VIEWPORT_Y, 17'(y));
    write_reg(REG_VIEWPORT_WIDTH, 17'(w));
    write_reg(REG_VIEWPORT_HEIGHT, 17'(h));
    write_reg(REG_DEPTH_NEAR, nr);
    write_reg(REG_DEPTH_FAR, fr);
  endtask

  // offer one vertex after a random gap, hold until accepted
  task automatic send_vertex(vertex_t v, window_t e);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk);
    vtx_in.valid = 1'b1;
    vtx_in.clip_x = v.x; vtx_in.clip_y = v.y;
    vtx_in.clip_z = v.z; vtx_in.clip_w = v.w;
    do @(posedge clk); while (!vtx_in.ready);
    pending_windows.push_back(e);
    @(negedge clk);
    vtx_in.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_windows.size() != 0 && !timed_out) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_w();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      default: return $urandom_range(0, 1) ? $signed($urandom_range(1, 32'h8_0000))
                                           : -$signed($urandom_range(1, 32'h8_0000));
    endcase
  endfunction

  // sink ready: a random wait before each item, plus one long hold-off
  initial begin
    int hold_n;
    win_out.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold_n = $urandom_range(0, 3);
      win_out.ready = 1'b0;
      repeat (hold_n) @(negedge clk);
      win_out.ready = !sink_hold;
      @(posedge clk);
      while (!(win_out.valid && win_out.ready)) begin
        @(negedge clk);
        win_out.ready = !sink_hold;
        @(posedge clk);
      end
      @(negedge clk);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    window_t e;
    if (!rst) begin
      if ((vtx_in.valid && vtx_in.ready) || (win_out.valid && win_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (win_out.valid && win_out.ready) begin
        if (pending_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected window item");
        end else begin
          e = pending_windows.pop_front();
          if (win_out.window_x !== e.wx || win_out.window_y !== e.wy ||
              win_out.window_depth !== e.depth || win_out.inverse_w !== e.inv ||
              win_out.w_zero !== e.wz) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp x=%h y=%h d=%h inv=%h wz=%b got x=%h y=%h d=%h inv=%h wz=%b",
                       e.wx, e.wy, e.depth, e.inv, e.wz, win_out.window_x,
                       win_out.window_y, win_out.window_depth, win_out.inverse_w,
                       win_out.w_zero);
          end
        end
      end
      if (idle_cycles > WATCHDOG) timed_out = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    row_t r;
    vertex_t v;
    window_t z;
    vtx_in.valid = 1'b0;
    vtx_in.clip_x = '0; vtx_in.clip_y = '0; vtx_in.clip_z = '0; vtx_in.clip_w = '0;
    vp_x = 0; vp_y = 0; vp_w = 1; vp_h = 1; dep_near = 0; dep_far = 17'd65536;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: after reset, span is zero so x and y sit at the origin
    z = '{wx: 0, wy: 0, depth: 32'sh4000, inv: 32'sh1_0000, wz: 1'b0};
    rows.push_back('{v: '{0, 0, 0, 32'sh1_0000}, has_exp: 1, e: z});
    z = '{wx: 0, wy: 0, depth: 32'sh4000, inv: Q_MAX, wz: 1'b1};
    rows.push_back('{v: '{0, 0, 0, 0}, has_exp: 1, e: z});
    z = '{wx: 0, wy: 0, depth: 32'sh2000_3FFF, inv: Q_MAX, wz: 1'b1};
    rows.push_back('{v: '{Q_MAX, Q_MIN, Q_MAX, 0}, has_exp: 1, e: z});
    z = '{wx: 0, wy: 0, depth: 32'sh8000, inv: 32'sh1_0000, wz: 1'b0};
    rows.push_back('{v: '{32'sh1_0000, -32'sh1_0000, 32'sh1_0000, 32'sh1_0000},
                     has_exp: 1, e: z});
    rows.push_back('{v: '{Q_MAX, Q_MAX, Q_MIN, 32'sd1}, has_exp: 0, e: z});
    rows.push_back('{v: '{Q_MIN, Q_MIN, Q_MAX, -32'sd1}, has_exp: 0, e: z});
    rows.push_back('{v: '{32'sd1, -32'sd1, 32'sd7, Q_MAX}, has_exp: 0, e: z});
    rows.push_back('{v: '{-32'sd5, 32'sd5, -32'sd1, Q_MIN}, has_exp: 0, e: z});
    rows.push_back('{v: '{32'sh8000, 32'sh4000, -32'sh2_0000, -32'sh1_0000},
                     has_exp: 0, e: z});
    foreach (rows[i]) begin
      r = rows[i];
      send_vertex(r.v, r.has_exp ? r.e : project_vertex(r.v));
    end
    drain();

    // wide viewport, extreme origin, reversed depth
    set_view(16'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF, 17'h1_0000, 17'h0);
    foreach (rows[i]) send_vertex(rows[i].v, project_vertex(rows[i].v));
    drain();

    // zero size acts as one, depth registers beyond 1.0
    set_view(16'h8000, 16'h7FFF, 15'h0, 15'h0, 17'h1_FFFF, 17'h1_FFFF);
    for (int i = 0; i < 6; i++) begin
      v = '{rand_coord(), rand_coord(), rand_coord(), rand_w()};
      send_vertex(v, project_vertex(v));
    end
    drain();

    // random phases with random setups; one long sink hold-off in phase 1
    for (int p = 0; p < 5; p++) begin
      set_view(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
               17'($urandom), 17'($urandom));
      if (p == 1) begin
        fork
          begin
            sink_hold = 1'b1;
            repeat (LONG_STALL) @(negedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        v = '{rand_coord(), rand_coord(), rand_coord(), rand_w()};
        send_vertex(v, project_vertex(v));
      end
      drain();
    end

    if (mismatches == 0 && pending_windows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
